/* sv/thmd_pkg.sv */
package thmd_pkg;

  // Instruction class codes
  localparam logic CLASS_MUL = 1'b0;
  localparam logic CLASS_DIV = 1'b1;

  // Dense operation numbers
  localparam logic [5:0] OP_MUL     = 6'd0;
  localparam logic [5:0] OP_MLA     = 6'd1;
  localparam logic [5:0] OP_MLS     = 6'd2;
  localparam logic [5:0] OP_SMULBB  = 6'd3;
  localparam logic [5:0] OP_SMLABB  = 6'd7;
  localparam logic [5:0] OP_SMUAD   = 6'd11;
  localparam logic [5:0] OP_SMUSD   = 6'd13;
  localparam logic [5:0] OP_SMLAD   = 6'd15;
  localparam logic [5:0] OP_SMLSD   = 6'd17;
  localparam logic [5:0] OP_SMULWB  = 6'd19;
  localparam logic [5:0] OP_SMLAWB  = 6'd21;
  localparam logic [5:0] OP_SMMUL   = 6'd23;
  localparam logic [5:0] OP_SMMLA   = 6'd25;
  localparam logic [5:0] OP_SMMLS   = 6'd27;
  localparam logic [5:0] OP_USAD8   = 6'd29;
  localparam logic [5:0] OP_USADA8  = 6'd30;
  localparam logic [5:0] OP_SMULL   = 6'd31;
  localparam logic [5:0] OP_UMULL   = 6'd32;
  localparam logic [5:0] OP_SMLAL   = 6'd33;
  localparam logic [5:0] OP_UMLAL   = 6'd34;
  localparam logic [5:0] OP_SMLALBB = 6'd35;
  localparam logic [5:0] OP_SMLALD  = 6'd39;
  localparam logic [5:0] OP_SMLSLD  = 6'd41;

  // Group selector
  localparam logic SEL_MUL_GROUP  = 1'b0;
  localparam logic SEL_LONG_GROUP = 1'b1;

  // Register number that marks "no accumulator"
  localparam logic [3:0] REG_PC = 4'hF;

  // Decoded request
  typedef struct packed {
    logic       insn_class;
    logic [5:0] op_code;
    logic [3:0] dest_reg;
    logic [3:0] first_src_reg;
    logic [3:0] second_src_reg;
    logic [3:0] accum_reg;
    logic       accum_used;
    logic [3:0] high_dest_reg;
    logic       is_long;
    logic       divide_signed;
    logic       undefined;
  } dec_result_t;

endpackage

/* sv/thmd_decode.sv */
module thmd_decode import thmd_pkg::*; (
  input  logic        operation,
  input  logic [15:0] first_halfword,
  input  logic [15:0] second_halfword,
  output dec_result_t result
);

  logic [2:0] op1;
  logic [3:0] rn;
  logic [3:0] rm;
  logic [3:0] hi_nib;
  logic [3:0] mid_nib;
  logic [1:0] mop2;
  logic [3:0] lop2;
  logic       acc;

  assign op1     = first_halfword[6:4];
  assign rn      = first_halfword[3:0];
  assign rm      = second_halfword[3:0];
  assign hi_nib  = second_halfword[15:12];
  assign mid_nib = second_halfword[11:8];
  assign mop2    = second_halfword[5:4];
  assign lop2    = second_halfword[7:4];
  assign acc     = (hi_nib != REG_PC);

  // Decode one request
  always_comb begin
    result = '0;
    if (operation == SEL_MUL_GROUP) begin
      result.insn_class     = CLASS_MUL;
      result.dest_reg       = mid_nib;
      result.first_src_reg  = rn;
      result.second_src_reg = rm;
      result.accum_used     = acc;
      unique case (op1)
        3'd0: begin
          if (mop2 == 2'd1) begin
            result.op_code    = OP_MLS;
            result.accum_used = 1'b1;
          end else begin
            result.op_code = acc ? OP_MLA : OP_MUL;
          end
        end
        3'd1: result.op_code = (acc ? OP_SMLABB : OP_SMULBB) + {4'b0, mop2};
        3'd2: result.op_code = (acc ? OP_SMLAD : OP_SMUAD) + {4'b0, mop2};
        3'd3: result.op_code = (acc ? OP_SMLAWB : OP_SMULWB) + {5'b0, mop2[0]};
        // op1 of 4 keeps the subtracting dual forms
        3'd4: result.op_code = (acc ? OP_SMLSD : OP_SMUSD) + {5'b0, mop2[0]};
        3'd5: result.op_code = (acc ? OP_SMMLA : OP_SMMUL) + {5'b0, mop2[0]};
        // op1 of 6 always reads the accumulator
        3'd6: begin
          result.op_code    = OP_SMMLS + {5'b0, mop2[0]};
          result.accum_used = 1'b1;
        end
        default: result.op_code = acc ? OP_USADA8 : OP_USAD8;
      endcase
      result.accum_reg = result.accum_used ? hi_nib : 4'h0;
    end else if ((op1 == 3'd1 || op1 == 3'd3) && lop2 == 4'hF) begin
      // Divide
      result.insn_class     = CLASS_DIV;
      result.dest_reg       = mid_nib;
      result.first_src_reg  = rn;
      result.second_src_reg = rm;
      result.divide_signed  = (op1 == 3'd1);
    end else begin
      // Long multiply forms; drop everything when undefined
      result.insn_class     = CLASS_MUL;
      result.dest_reg       = hi_nib;
      result.first_src_reg  = rn;
      result.second_src_reg = rm;
      result.high_dest_reg  = mid_nib;
      result.is_long        = 1'b1;
      if (lop2[3]) begin
        priority if (lop2[2] == 1'b0) begin
          result.op_code = OP_SMLALBB + {4'b0, lop2[1:0]};
        end else if (op1 == 3'd4) begin
          result.op_code = OP_SMLALD + {5'b0, lop2[0]};
        end else if (op1 == 3'd5) begin
          result.op_code = OP_SMLSLD + {5'b0, lop2[0]};
        end else begin
          result.undefined = 1'b1;
        end
      end else begin
        unique case (op1)
          3'd0:    result.op_code = OP_SMULL;
          3'd2:    result.op_code = OP_UMULL;
          3'd4:    result.op_code = OP_SMLAL;
          3'd6:    result.op_code = OP_UMLAL;
          default: result.undefined = 1'b1;
        endcase
      end
      if (result.undefined) begin
        result = '0;
        result.undefined = 1'b1;
      end
    end
  end

endmodule

/* sv/thumb32_multiply_divide_decode_top.sv */
// Decoder for 32-bit Thumb multiply and long multiply/divide instructions.
// A request is taken on any cycle with start high and busy low; busy is high
// only during reset and until the first clock edge with rst_n high. Each
// request gives one result, flagged by out_valid for one cycle: it is held
// in the input register, then goes through the decode logic into the result
// register. A new request may enter every cycle while busy is low, and the
// receiver cannot stall results, so throughput is one instruction per clock.
module thumb32_multiply_divide_decode_top import thmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_first_halfword,
  input  logic [15:0] in_second_halfword,
  output logic        out_valid,
  output logic        out_insn_class,
  output logic [5:0]  out_op_code,
  output logic [3:0]  out_dest_reg,
  output logic [3:0]  out_first_src_reg,
  output logic [3:0]  out_second_src_reg,
  output logic [3:0]  out_accum_reg,
  output logic        out_accum_used,
  output logic [3:0]  out_high_dest_reg,
  output logic        out_is_long,
  output logic        out_divide_signed,
  output logic        out_undefined
);

  logic        busy_r;
  logic        in_vld_r;
  logic        in_vld_nxt;
  logic        op_r;
  logic [15:0] hw1_r;
  logic [15:0] hw2_r;
  logic        out_vld_r;
  dec_result_t dec;
  dec_result_t res_r;

  assign busy       = busy_r;
  assign in_vld_nxt = start && !busy_r;

  // Hold busy through reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_nxt) begin
      op_r  <= in_operation;
      hw1_r <= in_first_halfword;
      hw2_r <= in_second_halfword;
    end
  end

  thmd_decode u_decode (
    .operation       (op_r),
    .first_halfword  (hw1_r),
    .second_halfword (hw2_r),
    .result          (dec)
  );

  // Advance into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      res_r <= dec;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_insn_class     = res_r.insn_class;
  assign out_op_code        = res_r.op_code;
  assign out_dest_reg       = res_r.dest_reg;
  assign out_first_src_reg  = res_r.first_src_reg;
  assign out_second_src_reg = res_r.second_src_reg;
  assign out_accum_reg      = res_r.accum_reg;
  assign out_accum_used     = res_r.accum_used;
  assign out_high_dest_reg  = res_r.high_dest_reg;
  assign out_is_long        = res_r.is_long;
  assign out_divide_signed  = res_r.divide_signed;
  assign out_undefined      = res_r.undefined;

`ifndef NO_ASSERTIONS
  // Every accepted request yields a result through the input and result registers
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted request produced no result");

  // No result without an earlier accepted request
  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a request");

  // Undefined encodings carry no operation
  a_undef_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_undefined) |->
      (out_op_code == OP_MUL && !out_is_long && !out_accum_used &&
       out_insn_class == CLASS_MUL))
    else $error("undefined result has live fields");

  // Divides are never long and never accumulate
  a_div_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_insn_class == CLASS_DIV) |->
      (!out_is_long && !out_accum_used && out_op_code == OP_MUL && !out_undefined))
    else $error("divide result has multiply fields");
`endif

endmodule

/* dv/decode_scoreboard_pkg.sv */
package decode_scoreboard_pkg;
  import thmd_pkg::*;

  // op1 field of the multiply group
  localparam logic [2:0] MG_PLAIN        = 3'd0;
  localparam logic [2:0] MG_HALF         = 3'd1;
  localparam logic [2:0] MG_DUAL_ADD     = 3'd2;
  localparam logic [2:0] MG_WORD         = 3'd3;
  localparam logic [2:0] MG_DUAL_SUB     = 3'd4;
  localparam logic [2:0] MG_MOST_SIG     = 3'd5;
  localparam logic [2:0] MG_MOST_SIG_SUB = 3'd6;

  // op2 of the multiply group that selects MLS
  localparam logic [1:0] MG_OP2_MLS = 2'd1;

  // op1 field of the long multiply and divide group
  localparam logic [2:0] LG_SMULL  = 3'd0;
  localparam logic [2:0] LG_SDIV   = 3'd1;
  localparam logic [2:0] LG_UMULL  = 3'd2;
  localparam logic [2:0] LG_UDIV   = 3'd3;
  localparam logic [2:0] LG_SMLAL  = 3'd4;
  localparam logic [2:0] LG_SMLSLD = 3'd5;
  localparam logic [2:0] LG_UMLAL  = 3'd6;

  // op2 codes of the long group
  localparam logic [3:0] LG_OP2_DIV  = 4'hF;
  localparam logic [1:0] LG_OP2_HALF = 2'b10;

  class decode_scoreboard;
    dec_result_t pending_decodes[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Work out the decode of one instruction
    function dec_result_t decode_insn(logic sel, logic [15:0] h1, logic [15:0] h2);
      dec_result_t r;
      logic [2:0] op1;
      logic [1:0] mop2;
      logic [3:0] lop2;
      logic [3:0] top_nib;
      logic [3:0] mid_nib;
      logic [5:0] op;
      logic acc;
      logic known;
      r = '0;
      op1 = h1[6:4];
      top_nib = h2[15:12];
      mid_nib = h2[11:8];
      op = '0;
      known = 1'b1;
      if (sel == SEL_MUL_GROUP) begin
        mop2 = h2[5:4];
        acc = (top_nib != REG_PC);
        case (op1)
          MG_PLAIN: begin
            if (mop2 == MG_OP2_MLS) begin
              op = OP_MLS;
              acc = 1'b1;
            end else begin
              op = acc ? OP_MLA : OP_MUL;
            end
          end
          MG_HALF:     op = (acc ? OP_SMLABB : OP_SMULBB) + {4'b0, mop2};
          MG_DUAL_ADD: op = (acc ? OP_SMLAD : OP_SMUAD) + {4'b0, mop2};
          MG_WORD:     op = (acc ? OP_SMLAWB : OP_SMULWB) + {5'b0, mop2[0]};
          MG_DUAL_SUB: op = (acc ? OP_SMLSD : OP_SMUSD) + {5'b0, mop2[0]};
          MG_MOST_SIG: op = (acc ? OP_SMMLA : OP_SMMUL) + {5'b0, mop2[0]};
          MG_MOST_SIG_SUB: begin
            op = OP_SMMLS + {5'b0, mop2[0]};
            acc = 1'b1;
          end
          default:     op = acc ? OP_USADA8 : OP_USAD8;
        endcase
        r.insn_class = CLASS_MUL;
        r.op_code = op;
        r.dest_reg = mid_nib;
        r.first_src_reg = h1[3:0];
        r.second_src_reg = h2[3:0];
        if (acc) begin
          r.accum_reg = top_nib;
          r.accum_used = 1'b1;
        end
      end else begin
        lop2 = h2[7:4];
        if ((op1 == LG_SDIV || op1 == LG_UDIV) && lop2 == LG_OP2_DIV) begin
          r.insn_class = CLASS_DIV;
          r.dest_reg = mid_nib;
          r.first_src_reg = h1[3:0];
          r.second_src_reg = h2[3:0];
          r.divide_signed = (op1 == LG_SDIV);
        end else begin
          // Halfword and dual forms have op2[3] set, plain forms clear
          if (lop2[3]) begin
            if (lop2[3:2] == LG_OP2_HALF) op = OP_SMLALBB + {4'b0, lop2[1:0]};
            else if (op1 == LG_SMLAL) op = OP_SMLALD + {5'b0, lop2[0]};
            else if (op1 == LG_SMLSLD) op = OP_SMLSLD + {5'b0, lop2[0]};
            else known = 1'b0;
          end else begin
            case (op1)
              LG_SMULL: op = OP_SMULL;
              LG_UMULL: op = OP_UMULL;
              LG_SMLAL: op = OP_SMLAL;
              LG_UMLAL: op = OP_UMLAL;
              default:  known = 1'b0;
            endcase
          end
          if (known) begin
            r.op_code = op;
            r.dest_reg = top_nib;
            r.first_src_reg = h1[3:0];
            r.second_src_reg = h2[3:0];
            r.high_dest_reg = mid_nib;
            r.is_long = 1'b1;
          end else begin
            r.undefined = 1'b1;
          end
        end
      end
      return r;
    endfunction

    function void note_request(logic sel, logic [15:0] h1, logic [15:0] h2);
      pending_decodes.push_back(decode_insn(sel, h1, h2));
    endfunction

    function int pending();
      return pending_decodes.size();
    endfunction

    task report(string what);
      $display("%0t decode mismatch: %s", $time, what);
      errors++;
    endtask

    task compare_field(string name, logic [5:0] got, logic [5:0] want);
      if (got !== want)
        report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Compare one result against the oldest outstanding decode
    task check_result(dec_result_t got);
      dec_result_t want;
      if (pending_decodes.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_decodes.pop_front();
        compare_field("insn_class", 6'(got.insn_class), 6'(want.insn_class));
        compare_field("op_code", got.op_code, want.op_code);
        compare_field("dest_reg", 6'(got.dest_reg), 6'(want.dest_reg));
        compare_field("first_src_reg", 6'(got.first_src_reg), 6'(want.first_src_reg));
        compare_field("second_src_reg", 6'(got.second_src_reg),
                      6'(want.second_src_reg));
        compare_field("accum_reg", 6'(got.accum_reg), 6'(want.accum_reg));
        compare_field("accum_used", 6'(got.accum_used), 6'(want.accum_used));
        compare_field("high_dest_reg", 6'(got.high_dest_reg), 6'(want.high_dest_reg));
        compare_field("is_long", 6'(got.is_long), 6'(want.is_long));
        compare_field("divide_signed", 6'(got.divide_signed), 6'(want.divide_signed));
        compare_field("undefined", 6'(got.undefined), 6'(want.undefined));
      end
    endtask
  endclass

endpackage

/* dv/testbench.sv */
module testbench;
  import thmd_pkg::*;
  import decode_scoreboard_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int ITEMS_PER_PHASE = 384;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [15:0] in_first_halfword;
  logic [15:0] in_second_halfword;
  logic        out_valid;
  logic        out_insn_class;
  logic [5:0]  out_op_code;
  logic [3:0]  out_dest_reg;
  logic [3:0]  out_first_src_reg;
  logic [3:0]  out_second_src_reg;
  logic [3:0]  out_accum_reg;
  logic        out_accum_used;
  logic [3:0]  out_high_dest_reg;
  logic        out_is_long;
  logic        out_divide_signed;
  logic        out_undefined;
  dec_result_t observed;
  int          stall_cycles = 0;

  decode_scoreboard sb;

  thumb32_multiply_divide_decode_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_first_halfword(in_first_halfword),
    .in_second_halfword(in_second_halfword),
    .out_valid(out_valid),
    .out_insn_class(out_insn_class),
    .out_op_code(out_op_code),
    .out_dest_reg(out_dest_reg),
    .out_first_src_reg(out_first_src_reg),
    .out_second_src_reg(out_second_src_reg),
    .out_accum_reg(out_accum_reg),
    .out_accum_used(out_accum_used),
    .out_high_dest_reg(out_high_dest_reg),
    .out_is_long(out_is_long),
    .out_divide_signed(out_divide_signed),
    .out_undefined(out_undefined)
  );

  assign observed = {out_insn_class, out_op_code, out_dest_reg, out_first_src_reg,
                     out_second_src_reg, out_accum_reg, out_accum_used,
                     out_high_dest_reg, out_is_long, out_divide_signed, out_undefined};

  // Directed instructions: {group, first halfword, second halfword}
  logic [32:0] directed_insns [0:24] = '{
    {SEL_MUL_GROUP, 16'hFB01, 16'hF203},   // MUL, Ra is the PC
    {SEL_MUL_GROUP, 16'hFB01, 16'h4203},   // MLA
    {SEL_MUL_GROUP, 16'hFB01, 16'hF213},   // MLS even with Ra the PC
    {SEL_MUL_GROUP, 16'hFB1A, 16'hF5B6},   // SMULTT
    {SEL_MUL_GROUP, 16'hFB1A, 16'h7526},   // SMLATB
    {SEL_MUL_GROUP, 16'hFB2C, 16'hF810},   // SMUADX
    {SEL_MUL_GROUP, 16'hFB33, 16'hF91E},   // SMULWT
    {SEL_MUL_GROUP, 16'hFB43, 16'h2A2E},   // dual subtract, op2 bit 1 ignored
    {SEL_MUL_GROUP, 16'hFB43, 16'hFA3E},   // SMUSDX
    {SEL_MUL_GROUP, 16'hFB55, 16'hF014},   // SMMULR
    {SEL_MUL_GROUP, 16'hFB65, 16'hF014},   // SMMLSR always reads Ra
    {SEL_MUL_GROUP, 16'hFB77, 16'hF000},   // USAD8
    {SEL_MUL_GROUP, 16'hFB77, 16'h1000},   // USADA8
    {SEL_MUL_GROUP, 16'hFFFF, 16'hFFFF},
    {SEL_MUL_GROUP, 16'h0000, 16'h0000},
    {SEL_LONG_GROUP, 16'hFB9C, 16'h1DF2},  // SDIV
    {SEL_LONG_GROUP, 16'hFBB7, 16'h0AF9},  // UDIV
    {SEL_LONG_GROUP, 16'hFB9C, 16'h1DE2},  // dual form with a bad op1
    {SEL_LONG_GROUP, 16'hFBF5, 16'h34B6},  // SMLALTT
    {SEL_LONG_GROUP, 16'hFBC5, 16'h34D6},  // SMLALDX
    {SEL_LONG_GROUP, 16'hFBD5, 16'h34C6},  // SMLSLD
    {SEL_LONG_GROUP, 16'hFBA5, 16'h3476},  // UMULL
    {SEL_LONG_GROUP, 16'hFBE5, 16'h3406},  // UMLAL
    {SEL_LONG_GROUP, 16'hFFFF, 16'hFFFF},  // undefined
    {SEL_LONG_GROUP, 16'h0000, 16'h0000}   // SMULL
  };

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Note each accepted request first, then check whatever comes out
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_request(in_operation, in_first_halfword, in_second_halfword);
    if (out_valid)
      sb.check_result(observed);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one request, idling first at random; return at a falling edge
  task send_request(logic sel, logic [15:0] h1, logic [15:0] h2, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_operation <= sel;
    in_first_halfword <= h1;
    in_second_halfword <= h2;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Mostly realistic encodings with random fields
  task send_random(int idle_pct);
    logic sel;
    logic [15:0] h1;
    logic [15:0] h2;
    sel = 1'($urandom_range(1));
    h1 = 16'($urandom);
    h2 = 16'($urandom);
    if ($urandom_range(99) < 70)
      h1[15:7] = {8'hFB, sel};
    if (sel == SEL_MUL_GROUP && $urandom_range(99) < 30)
      h2[15:12] = REG_PC;
    if (sel == SEL_LONG_GROUP && $urandom_range(99) < 25)
      h2[7:4] = LG_OP2_DIV;
    send_request(sel, h1, h2, idle_pct);
  endtask

  initial begin
    int phase_idle [0:2];
    phase_idle = '{19, 59, 0};
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = 1'b0;
    in_first_halfword = '0;
    in_second_halfword = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_insns[i])
      send_request(directed_insns[i][32], directed_insns[i][31:16],
                   directed_insns[i][15:0], 0);
    foreach (phase_idle[p])
      repeat (ITEMS_PER_PHASE) send_random(phase_idle[p]);
    start <= 1'b0;

    // Drain outstanding decodes, then watch for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
sv/thmd_pkg.sv
sv/thmd_decode.sv
sv/thumb32_multiply_divide_decode_top.sv
dv/decode_scoreboard_pkg.sv
dv/testbench.sv
